[rtl/core/sed_pkg.sv]
// sed_pkg: shared types and constants for the string escape decoder
// holds request structs, decoder mode enum, result kinds and character codes
// no dependencies
package sed_pkg;

  // request fields of the input channel
  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
  } in_req_t;

  // request fields of the result channel
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_req_t;

  // decoder mode
  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_OCT    = 2'd2,
    MODE_HEX    = 2'd3
  } mode_t;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // reset value of the closing quote register
  localparam logic [7:0] QUOTE_RESET = 8'h22;

  // result queue size
  localparam int QDEPTH = 4;

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_UC_X   = 8'h58;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_7  = 8'h37;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  // control codes produced by letter escapes
  localparam logic [7:0] CC_BEL = 8'd7;
  localparam logic [7:0] CC_BS  = 8'd8;
  localparam logic [7:0] CC_FF  = 8'd12;
  localparam logic [7:0] CC_LF  = 8'd10;
  localparam logic [7:0] CC_CR  = 8'd13;
  localparam logic [7:0] CC_HT  = 8'd9;
  localparam logic [7:0] CC_VT  = 8'd11;

endpackage

[rtl/core/sed_decode.sv]
// sed_decode: escape decoding stage with mode and escape value state
// turns one registered request combinationally into up to two results
// depends on sed_pkg
module sed_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sed_pkg::in_req_t  req,
  input  logic [7:0]        quote,
  output logic [1:0]        res_n,
  output sed_pkg::out_req_t res0,
  output sed_pkg::out_req_t res1
);

  sed_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]     esc_r, esc_nxt;

  logic [7:0]        h;
  logic              plain_emit;
  sed_pkg::mode_t    plain_mode;
  sed_pkg::out_req_t plain_res;
  sed_pkg::out_req_t esc_res;
  logic              is_oct;
  logic              is_hex;
  logic [3:0]        hex_val;

  assign h = req.in_byte;

  // plain text handling of the current byte
  always_comb begin
    plain_emit = 1'b1;
    plain_mode = sed_pkg::MODE_PLAIN;
    plain_res  = '0;
    if (h == sed_pkg::CH_BSLASH) begin
      plain_emit = 1'b0;
      plain_mode = sed_pkg::MODE_BSLASH;
    end else if (h == quote) begin
      plain_res.kind = sed_pkg::KIND_CLOSE;
    end else begin
      plain_res.kind     = sed_pkg::KIND_BYTE;
      plain_res.out_byte = h;
    end
  end

  // digit classification
  always_comb begin
    is_oct  = (h >= sed_pkg::CH_DIG_0) && (h <= sed_pkg::CH_DIG_7);
    is_hex  = 1'b1;
    hex_val = h[3:0];
    if ((h >= sed_pkg::CH_DIG_0) && (h <= sed_pkg::CH_DIG_9)) begin
      hex_val = h[3:0];
    end else if (((h >= sed_pkg::CH_LC_A) && (h <= sed_pkg::CH_LC_F)) ||
                 ((h >= sed_pkg::CH_UC_A) && (h <= sed_pkg::CH_UC_F))) begin
      hex_val = h[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // flushed numeric escape byte
  always_comb begin
    esc_res          = '0;
    esc_res.kind     = sed_pkg::KIND_BYTE;
    esc_res.out_byte = esc_r;
  end

  // next state and results
  always_comb begin
    mode_nxt = mode_r;
    esc_nxt  = esc_r;
    res_n    = 2'd0;
    res0     = '0;
    res1     = '0;
    if (req.action == sed_pkg::ACT_END) begin
      mode_nxt = sed_pkg::MODE_PLAIN;
      esc_nxt  = '0;
      if ((mode_r == sed_pkg::MODE_OCT) || (mode_r == sed_pkg::MODE_HEX)) begin
        res0      = esc_res;
        res1.kind = sed_pkg::KIND_END;
        res_n     = 2'd2;
      end else begin
        res0.kind = sed_pkg::KIND_END;
        res_n     = 2'd1;
      end
    end else begin
      unique case (mode_r)
        sed_pkg::MODE_PLAIN: begin
          mode_nxt = plain_mode;
          res0     = plain_res;
          res_n    = {1'b0, plain_emit};
        end
        sed_pkg::MODE_BSLASH: begin
          mode_nxt      = sed_pkg::MODE_PLAIN;
          res0.kind     = sed_pkg::KIND_BYTE;
          res_n         = 2'd1;
          unique case (h) inside
            sed_pkg::CH_LC_A: res0.out_byte = sed_pkg::CC_BEL;
            sed_pkg::CH_LC_B: res0.out_byte = sed_pkg::CC_BS;
            sed_pkg::CH_LC_F: res0.out_byte = sed_pkg::CC_FF;
            sed_pkg::CH_LC_N: res0.out_byte = sed_pkg::CC_LF;
            sed_pkg::CH_LC_R: res0.out_byte = sed_pkg::CC_CR;
            sed_pkg::CH_LC_T: res0.out_byte = sed_pkg::CC_HT;
            sed_pkg::CH_LC_V: res0.out_byte = sed_pkg::CC_VT;
            sed_pkg::CH_BSLASH, sed_pkg::CH_QMARK,
            sed_pkg::CH_SQUOTE, sed_pkg::CH_DQUOTE: res0.out_byte = h;
            sed_pkg::CH_LC_X, sed_pkg::CH_UC_X: begin
              esc_nxt  = '0;
              mode_nxt = sed_pkg::MODE_HEX;
              res_n    = 2'd0;
            end
            default: begin
              if (is_oct) begin
                esc_nxt  = {5'd0, h[2:0]};
                mode_nxt = sed_pkg::MODE_OCT;
                res_n    = 2'd0;
              end else begin
                // unknown escape drops the backslash
                mode_nxt = plain_mode;
                res0     = plain_res;
                res_n    = {1'b0, plain_emit};
              end
            end
          endcase
        end
        sed_pkg::MODE_OCT: begin
          if (is_oct) begin
            esc_nxt = {esc_r[4:0], h[2:0]};
          end else begin
            mode_nxt = plain_mode;
            res0     = esc_res;
            res1     = plain_res;
            res_n    = plain_emit ? 2'd2 : 2'd1;
          end
        end
        sed_pkg::MODE_HEX: begin
          if (is_hex) begin
            esc_nxt = {esc_r[3:0], hex_val};
          end else begin
            mode_nxt = plain_mode;
            res0     = esc_res;
            res1     = plain_res;
            res_n    = plain_emit ? 2'd2 : 2'd1;
          end
        end
        default: begin
          mode_nxt = sed_pkg::MODE_PLAIN;
        end
      endcase
    end
    // mark the final result of this request
    res0.last = (res_n == 2'd1);
    res1.last = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sed_pkg::MODE_PLAIN;
      esc_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
    end
  end

  // end of input always leaves plain mode with a cleared value
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (req.action == sed_pkg::ACT_END)) |=>
      ((mode_r == sed_pkg::MODE_PLAIN) && (esc_r == 8'd0)))
    else $error("end of input did not clear decoder state");

endmodule

[rtl/core/sed_out_queue.sv]
// sed_out_queue: small result queue taking up to two results per cycle
// decouples the decode stage from the result channel stall
// depends on sed_pkg
module sed_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  sed_pkg::out_req_t push0,
  input  sed_pkg::out_req_t push1,
  output logic              room,
  output logic              out_vld,
  input  logic              out_stall,
  output sed_pkg::out_req_t out_req
);

  localparam int PW = $clog2(sed_pkg::QDEPTH);
  localparam int CW = $clog2(sed_pkg::QDEPTH + 1);

  sed_pkg::out_req_t mem [sed_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wr_ptr_p1;
  logic          pop;

  assign out_vld   = (cnt_r != '0);
  assign out_req   = mem[rd_ptr_r];
  assign pop       = out_vld && !out_stall;
  assign room      = (cnt_r <= CW'(sed_pkg::QDEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PW'(1);

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  // pushes only happen with space for two results
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room)
    else $error("result queue overflow");

  // count never exceeds the queue size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(sed_pkg::QDEPTH))
    else $error("result queue count out of range");

  // pointer distance matches the count
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[PW-1:0])
    else $error("result queue pointers disagree with count");

endmodule

[rtl/core/string_escape_decoder_unit.sv]
// string_escape_decoder_unit: decodes quoted string bytes and escapes
// each accepted request is registered, then decoded into the result queue;
// one request per cycle while the queue has room, a request giving two results
// takes two output slots, limited by the single-result-per-cycle output port
// synchronous active-low reset returns to plain mode, clears the escape value,
// empties the queue and sets the closing quote to double quote
module string_escape_decoder_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_stall,
  input  sed_pkg::in_req_t  in_req,
  output logic              out_vld,
  input  logic              out_stall,
  output sed_pkg::out_req_t out_req,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic              in_vld_r, in_vld_nxt;
  sed_pkg::in_req_t  in_req_r;
  logic [7:0]        quote_r;
  logic              room;
  logic              fire;
  logic              accept;
  logic [1:0]        dec_n;
  logic [1:0]        push_n;
  sed_pkg::out_req_t dec0;
  sed_pkg::out_req_t dec1;

  // input register handshake
  assign fire     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign accept   = in_vld && !in_stall;
  assign push_n   = fire ? dec_n : 2'd0;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_req_r <= in_req;
    end
  end

  // closing quote register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= sed_pkg::QUOTE_RESET;
    end else if (cfg_we) begin
      quote_r <= cfg_wdata;
    end
  end

  // decode stage
  sed_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (in_req_r),
    .quote (quote_r),
    .res_n (dec_n),
    .res0  (dec0),
    .res1  (dec1)
  );

  // result queue
  sed_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (dec0),
    .push1     (dec1),
    .room      (room),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule
